### design/rcsfr_pkg.sv
// ----------------------------------------------------------------------------
// rcsfr_pkg
// Shared constants and controller/datapath interface types for the serial
// RC frame receiver.
// ----------------------------------------------------------------------------
package rcsfr_pkg;

   localparam int FRAME_BYTES   = 32;
   localparam int CHANNEL_COUNT = 14;

   localparam int ADDR_W   = $clog2(FRAME_BYTES);
   localparam int CHAN_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int IDX_MIN  = $clog2(2 * CHANNEL_COUNT + 2);
   localparam int IDX_W    = (IDX_MIN > ADDR_W) ? IDX_MIN : ADDR_W + 1;

   localparam logic [7:0]  HEADER_RESET = 8'h20;
   localparam logic [15:0] SUM_INIT     = 16'hFFFF;

   typedef struct packed {
      logic start;       // header word taken while hunting
      logic store;       // frame word taken while collecting
      logic chan_clear;  // frame good, rewind channel counter
      logic fetch;       // read the current channel's byte pair
      logic chan_next;   // advance to the next channel
      logic show_error;  // present the checksum-error result
   } cmd_type;

   typedef struct packed {
      logic hdr_match;
      logic frame_end;
      logic sum_ok;
      logic chan_last;
   } stat_type;

   typedef enum logic [4:0] {
      ST_HUNT    = 5'b00001,
      ST_COLLECT = 5'b00010,
      ST_FETCH   = 5'b00100,
      ST_SHOW    = 5'b01000,
      ST_FAULT   = 5'b10000
   } state_type;

endpackage

### design/rcsfr_ctrl.sv
// ----------------------------------------------------------------------------
// rcsfr_ctrl
// Frame sequencer: hunts for the header, collects the frame, then steps
// through the channel results or the checksum-error result.
// ----------------------------------------------------------------------------
module rcsfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  rcsfr_pkg::stat_type stat,
   output rcsfr_pkg::cmd_type  cmd
);
   import rcsfr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.show_error = (state_ff == ST_FAULT);
      case (state_ff)
         ST_HUNT: begin
            if (req_valid && stat.hdr_match) begin
               cmd.start = 1'b1;
               state_in  = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               if (stat.frame_end) begin
                  if (stat.sum_ok) begin
                     cmd.chan_clear = 1'b1;
                     state_in       = ST_FETCH;
                  end else begin
                     state_in = ST_FAULT;
                  end
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               if (stat.chan_last) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.chan_next = 1'b1;
                  state_in      = ST_FETCH;
               end
            end
         end
         ST_FAULT: begin
            if (!rsp_stall) begin
               state_in = ST_HUNT;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   assign req_stall = !((state_ff == ST_HUNT) || (state_ff == ST_COLLECT));
   assign rsp_valid = (state_ff == ST_SHOW) || (state_ff == ST_FAULT);

endmodule

### design/rcsfr_datapath.sv
// ----------------------------------------------------------------------------
// rcsfr_datapath
// Frame store, position counter, checksum accumulator, trailer capture,
// header register and the channel read-out registers.
// ----------------------------------------------------------------------------
module rcsfr_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_rx_byte,
   input  logic               csr_we,
   input  logic [7:0]         csr_header_byte,
   input  rcsfr_pkg::cmd_type  cmd,
   output rcsfr_pkg::stat_type stat,
   output logic               rsp_status,
   output logic [3:0]         rsp_channel_number,
   output logic [15:0]        rsp_channel_value,
   output logic               rsp_last_of_frame
);
   import rcsfr_pkg::*;

   logic [7:0]        store_mem [FRAME_BYTES];
   logic [7:0]        header_ff;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        trail_lo_ff;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [7:0]        rd_lo_ff, rd_hi_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [IDX_W-1:0]  lo_idx, hi_idx;
   logic [3:0]        chan_num;
   logic              take;

   assign take    = cmd.start || cmd.store;
   assign wr_addr = cmd.start ? '0 : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else if (csr_we) begin
         header_ff <= csr_header_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= SUM_INIT;
         chan_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         chan_ff <= chan_in;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (cmd.start) begin
         pos_in = ADDR_W'(1);
         sum_in = SUM_INIT - {8'h00, req_rx_byte};
      end else if (cmd.store) begin
         pos_in = stat.frame_end ? '0 : pos_ff + ADDR_W'(1);
         if ((32'(pos_ff) + 32'd2) < 32'(FRAME_BYTES)) begin
            sum_in = sum_ff - {8'h00, req_rx_byte};
         end
      end
   end

   always_comb begin
      chan_in = chan_ff;
      if (cmd.chan_clear) begin
         chan_in = '0;
      end else if (cmd.chan_next) begin
         chan_in = chan_ff + CHAN_W'(1);
      end
   end

   // trailer low byte
   always_ff @(posedge clock) begin
      if (cmd.store && (32'(pos_ff) == FRAME_BYTES - 2)) begin
         trail_lo_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         store_mem[wr_addr] <= req_rx_byte;
      end
   end

   assign lo_idx = IDX_W'({chan_ff, 1'b0}) + IDX_W'(2);
   assign hi_idx = IDX_W'({chan_ff, 1'b0}) + IDX_W'(3);

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_lo_ff <= (lo_idx < IDX_W'(FRAME_BYTES)) ? store_mem[lo_idx[ADDR_W-1:0]] : 8'h00;
         rd_hi_ff <= (hi_idx < IDX_W'(FRAME_BYTES)) ? store_mem[hi_idx[ADDR_W-1:0]] : 8'h00;
      end
   end

   assign stat.hdr_match = (req_rx_byte == header_ff);
   assign stat.frame_end = (32'(pos_ff) == FRAME_BYTES - 1);
   assign stat.sum_ok    = ({req_rx_byte, trail_lo_ff} == sum_ff);
   assign stat.chan_last = (32'(chan_ff) == CHANNEL_COUNT - 1);

   assign chan_num = 4'(chan_ff) + 4'd1;

   assign rsp_status         = cmd.show_error;
   assign rsp_channel_number = cmd.show_error ? 4'd0 : chan_num;
   assign rsp_channel_value  = cmd.show_error ? 16'h0000 : {rd_hi_ff, rd_lo_ff};
   assign rsp_last_of_frame  = cmd.show_error || stat.chan_last;

endmodule

### design/rc_serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver
// Serial RC frame decoder: header hunt, frame collection, checksum check
// and channel read-out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received serial word per handshake (req_valid / req_stall).
//            Words are taken one per cycle while hunting or collecting; words
//            that do not match the header while hunting are dropped.
//   rsp_*  : results (rsp_valid / rsp_stall). A good frame gives one word per
//            channel, the final one flagged by rsp_last_of_frame; a bad
//            checksum gives a single error word with rsp_status set.
//   csr_*  : header byte write; csr_ready is always high. Write only while
//            no frame is in progress.
// Timing: after the last frame word the controller steps to ST_FETCH (store
//   read), then ST_SHOW (present); each later channel word repeats the pair,
//   set by the single registered read of the frame store per channel.
//   A checksum error word appears in the cycle after the last frame word.
// req_stall is high from the last frame word until the final result word
//   is taken; a stalled result holds. Reset returns to hunting with header
//   byte 0x20.
// ----------------------------------------------------------------------------
module rc_serial_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [3:0]  rsp_channel_number,
   output logic [15:0] rsp_channel_value,
   output logic        rsp_last_of_frame,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_header_byte
);
   import rcsfr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   rcsfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcsfr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .csr_we             (csr_valid && csr_ready),
      .csr_header_byte    (csr_header_byte),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_channel_number (rsp_channel_number),
      .rsp_channel_value  (rsp_channel_value),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

endmodule
